// ===== rtl/udls_pkg.sv =====
// shared types, constants and character tables for the diff line summarizer
`default_nettype none

package udls_pkg;

  localparam int LINE_BUFFER_DEF = 1024;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int OUT_WIDTH       = 32;
  localparam int NUM_PREFIX      = 6;
  localparam int PFX_TEXT_W      = 88;
  localparam int BIN_TEXT_W      = 104;

  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_B     = 8'h42;

  localparam logic [2:0] PFX_DIFF_GIT = 3'd0;
  localparam logic [2:0] PFX_OLD_HDR  = 3'd1;
  localparam logic [2:0] PFX_NEW_HDR  = 3'd2;
  localparam logic [2:0] PFX_HUNK     = 3'd3;
  localparam logic [2:0] PFX_PLUS3    = 3'd4;
  localparam logic [2:0] PFX_MINUS3   = 3'd5;

  localparam logic [3:0] BIN_LEN = 4'd13;

  localparam logic [PFX_TEXT_W-1:0] TXT_DIFF_GIT = "diff --git ";
  localparam logic [PFX_TEXT_W-1:0] TXT_OLD_HDR  = "--- ";
  localparam logic [PFX_TEXT_W-1:0] TXT_NEW_HDR  = "+++ ";
  localparam logic [PFX_TEXT_W-1:0] TXT_HUNK     = "@@";
  localparam logic [PFX_TEXT_W-1:0] TXT_PLUS3    = "+++";
  localparam logic [PFX_TEXT_W-1:0] TXT_MINUS3   = "---";
  localparam logic [BIN_TEXT_W-1:0] TXT_BINARY   = "Binary files ";

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_FILE,
    KIND_OLD_HDR,
    KIND_NEW_HDR,
    KIND_HUNK,
    KIND_ADDED,
    KIND_DELETED,
    KIND_BINARY
  } line_kind_t;

  typedef struct packed {
    logic       line_end;
    logic       patch_end;
    line_kind_t kind;
  } line_event_t;

  function automatic logic [3:0] pfx_len(input logic [2:0] k);
    logic [3:0] len;
    case (k)
      PFX_DIFF_GIT: len = 4'd11;
      PFX_OLD_HDR:  len = 4'd4;
      PFX_NEW_HDR:  len = 4'd4;
      PFX_HUNK:     len = 4'd2;
      PFX_PLUS3:    len = 4'd3;
      PFX_MINUS3:   len = 4'd3;
      default:      len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] pfx_char(input logic [2:0] k, input logic [3:0] pos);
    logic [PFX_TEXT_W-1:0] s;
    logic [3:0]            len;
    logic [3:0]            idx;
    logic [7:0]            c;
    len = pfx_len(k);
    case (k)
      PFX_DIFF_GIT: s = TXT_DIFF_GIT;
      PFX_OLD_HDR:  s = TXT_OLD_HDR;
      PFX_NEW_HDR:  s = TXT_NEW_HDR;
      PFX_HUNK:     s = TXT_HUNK;
      PFX_PLUS3:    s = TXT_PLUS3;
      PFX_MINUS3:   s = TXT_MINUS3;
      default:      s = '0;
    endcase
    if (pos < len) begin
      idx = len - 4'd1 - pos;
      c = s[{idx, 3'b000} +: 8];
    end else begin
      c = BYTE_NUL;
    end
    return c;
  endfunction

  function automatic logic [7:0] bin_char(input logic [3:0] p);
    logic [3:0] idx;
    logic [7:0] c;
    if (p < BIN_LEN) begin
      idx = BIN_LEN - 4'd1 - p;
      c = TXT_BINARY[{idx, 3'b000} +: 8];
    end else begin
      c = BYTE_NUL;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/udls_line_scan.sv =====
// per-line prefix and binary-marker matching and line classification
`default_nettype none

module udls_line_scan #(
  parameter int LINE_BUFFER = udls_pkg::LINE_BUFFER_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic [7:0]           text_byte,
  output udls_pkg::line_event_t     evt
);
  import udls_pkg::*;

  localparam int PW = $clog2(LINE_BUFFER);
  localparam logic [PW-1:0] POS_MAX = PW'(LINE_BUFFER - 1);

  logic [PW-1:0]         pos_r, pos_nxt;
  logic [NUM_PREFIX-1:0] flags_r, flags_nxt;
  logic [7:0]            first_r, first_nxt;
  logic [3:0]            prog_r, prog_nxt;
  logic                  seen_r, seen_nxt;
  logic [NUM_PREFIX-1:0] has_pfx;
  logic                  line_end;
  logic                  patch_end;
  line_kind_t            kind;

  assign patch_end = (text_byte == BYTE_NUL);
  assign line_end  = patch_end || (text_byte == BYTE_LF);

  always_comb begin
    for (int k = 0; k < NUM_PREFIX; k++) begin
      has_pfx[k] = flags_r[k] && (pos_r >= PW'(pfx_len(3'(k))));
    end
    if (has_pfx[PFX_DIFF_GIT]) begin
      kind = KIND_FILE;
    end else if (has_pfx[PFX_OLD_HDR]) begin
      kind = KIND_OLD_HDR;
    end else if (has_pfx[PFX_NEW_HDR]) begin
      kind = KIND_NEW_HDR;
    end else if (has_pfx[PFX_HUNK]) begin
      kind = KIND_HUNK;
    end else if (pos_r != '0 && first_r == CHAR_PLUS && !has_pfx[PFX_PLUS3]) begin
      kind = KIND_ADDED;
    end else if (pos_r != '0 && first_r == CHAR_MINUS && !has_pfx[PFX_MINUS3]) begin
      kind = KIND_DELETED;
    end else if (seen_r) begin
      kind = KIND_BINARY;
    end else begin
      kind = KIND_NONE;
    end
  end

  assign evt = '{line_end: line_end, patch_end: patch_end, kind: kind};

  always_comb begin
    pos_nxt   = pos_r;
    flags_nxt = flags_r;
    first_nxt = first_r;
    prog_nxt  = prog_r;
    seen_nxt  = seen_r;
    if (step) begin
      if (line_end) begin
        pos_nxt   = '0;
        flags_nxt = '1;
        first_nxt = BYTE_NUL;
        prog_nxt  = '0;
        seen_nxt  = 1'b0;
      end else if (pos_r < POS_MAX) begin
        if (pos_r == '0) begin
          first_nxt = text_byte;
        end
        for (int k = 0; k < NUM_PREFIX; k++) begin
          if (pos_r < PW'(pfx_len(3'(k))) && text_byte != pfx_char(3'(k), pos_r[3:0])) begin
            flags_nxt[k] = 1'b0;
          end
        end
        if (!seen_r) begin
          if (text_byte == bin_char(prog_r)) begin
            if (prog_r + 4'd1 >= BIN_LEN) begin
              seen_nxt = 1'b1;
              prog_nxt = '0;
            end else begin
              prog_nxt = prog_r + 4'd1;
            end
          end else begin
            prog_nxt = (text_byte == CHAR_B) ? 4'd1 : 4'd0;
          end
        end
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      flags_r <= '1;
      first_r <= BYTE_NUL;
      prog_r  <= '0;
      seen_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      flags_r <= flags_nxt;
      first_r <= first_nxt;
      prog_r  <= prog_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/udls_tally.sv =====
// saturating patch totals and sticky flags, updated once per line
`default_nettype none

module udls_tally #(
  parameter int COUNT_WIDTH = udls_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire udls_pkg::line_event_t  evt,
  output logic [COUNT_WIDTH-1:0]      file_nxt,
  output logic [COUNT_WIDTH-1:0]      hunk_nxt,
  output logic [COUNT_WIDTH-1:0]      added_nxt,
  output logic [COUNT_WIDTH-1:0]      deleted_nxt,
  output logic                        binary_nxt,
  output logic                        malformed_nxt
);
  import udls_pkg::*;

  logic [COUNT_WIDTH-1:0] file_r, hunk_r, added_r, deleted_r;
  logic                   binary_r, malformed_r, old_hdr_r;
  logic                   old_hdr_nxt;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + COUNT_WIDTH'(1);
  endfunction

  // totals including the line that ends with this byte
  always_comb begin
    file_nxt      = file_r;
    hunk_nxt      = hunk_r;
    added_nxt     = added_r;
    deleted_nxt   = deleted_r;
    binary_nxt    = binary_r;
    malformed_nxt = malformed_r;
    old_hdr_nxt   = old_hdr_r;
    unique case (evt.kind)
      KIND_FILE: begin
        file_nxt    = sat_inc(file_r);
        old_hdr_nxt = 1'b0;
      end
      KIND_OLD_HDR: old_hdr_nxt = 1'b1;
      KIND_NEW_HDR: begin
        if (!old_hdr_r) begin
          malformed_nxt = 1'b1;
        end
      end
      KIND_HUNK:    hunk_nxt    = sat_inc(hunk_r);
      KIND_ADDED:   added_nxt   = sat_inc(added_r);
      KIND_DELETED: deleted_nxt = sat_inc(deleted_r);
      KIND_BINARY:  binary_nxt  = 1'b1;
      KIND_NONE:    ;
      default:      ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && evt.patch_end)) begin
      file_r      <= '0;
      hunk_r      <= '0;
      added_r     <= '0;
      deleted_r   <= '0;
      binary_r    <= 1'b0;
      malformed_r <= 1'b0;
      old_hdr_r   <= 1'b0;
    end else if (step && evt.line_end) begin
      file_r      <= file_nxt;
      hunk_r      <= hunk_nxt;
      added_r     <= added_nxt;
      deleted_r   <= deleted_nxt;
      binary_r    <= binary_nxt;
      malformed_r <= malformed_nxt;
      old_hdr_r   <= old_hdr_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/unified_diff_line_summarizer_unit.sv =====
// top level: input register, line scanner, tally and summary output register
//
// usage
//   the in channel takes one patch character per request on in_text_byte
//   (valid/ready). a newline ends a line; a zero byte ends the patch.
//   only the zero byte yields a request on the out channel, carrying the
//   file, hunk, added and deleted line totals and the binary and malformed
//   flags; the block then clears itself for the next patch.
//   throughput is one character per cycle unless a zero byte waits on a
//   held summary; line scan and counter update are combinational between
//   input and output registers; out_valid loads with the summary registers.
//   a pending summary does not stop newline or text characters; only a
//   further zero byte waits in the input register until out_ready takes
//   the held summary, and in_ready drops while it waits.
//   synchronous reset (rst_n low) empties both registers and clears all
//   line state and totals.
`default_nettype none

module unified_diff_line_summarizer_unit #(
  parameter int LINE_BUFFER = udls_pkg::LINE_BUFFER_DEF,
  parameter int COUNT_WIDTH = udls_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_text_byte,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [udls_pkg::OUT_WIDTH-1:0]    out_file_total,
  output logic [udls_pkg::OUT_WIDTH-1:0]    out_hunk_total,
  output logic [udls_pkg::OUT_WIDTH-1:0]    out_added_total,
  output logic [udls_pkg::OUT_WIDTH-1:0]    out_deleted_total,
  output logic                              out_binary_flag,
  output logic                              out_malformed
);
  import udls_pkg::*;

  logic                   in_valid_r, in_valid_nxt;
  logic [7:0]             in_byte_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_WIDTH-1:0]   file_r, hunk_r, added_r, deleted_r;
  logic                   binary_r, malformed_r;
  logic                   can_proc;
  logic                   step;
  line_event_t            evt;
  logic [COUNT_WIDTH-1:0] file_nxt, hunk_nxt, added_nxt, deleted_nxt;
  logic                   binary_nxt, malformed_nxt;

  assign can_proc = (in_byte_r != BYTE_NUL) || !out_valid_r || out_ready;
  assign step     = in_valid_r && can_proc;
  assign in_ready = !in_valid_r || can_proc;

  udls_line_scan #(
    .LINE_BUFFER(LINE_BUFFER)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .text_byte (in_byte_r),
    .evt       (evt)
  );

  udls_tally #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_tally (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .evt           (evt),
    .file_nxt      (file_nxt),
    .hunk_nxt      (hunk_nxt),
    .added_nxt     (added_nxt),
    .deleted_nxt   (deleted_nxt),
    .binary_nxt    (binary_nxt),
    .malformed_nxt (malformed_nxt)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = (out_valid_r && !out_ready) || (step && evt.patch_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_text_byte;
    end
    if (step && evt.patch_end) begin
      file_r      <= OUT_WIDTH'(file_nxt);
      hunk_r      <= OUT_WIDTH'(hunk_nxt);
      added_r     <= OUT_WIDTH'(added_nxt);
      deleted_r   <= OUT_WIDTH'(deleted_nxt);
      binary_r    <= binary_nxt;
      malformed_r <= malformed_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_file_total    = file_r;
  assign out_hunk_total    = hunk_r;
  assign out_added_total   = added_r;
  assign out_deleted_total = deleted_r;
  assign out_binary_flag   = binary_r;
  assign out_malformed     = malformed_r;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench for the unified diff line summarizer: directed and random patches, scoreboard
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import udls_pkg::*;

  typedef struct {
    logic [COUNT_WIDTH_DEF-1:0] files;
    logic [COUNT_WIDTH_DEF-1:0] hunks;
    logic [COUNT_WIDTH_DEF-1:0] added;
    logic [COUNT_WIDTH_DEF-1:0] deleted;
    logic                       binary;
    logic                       malformed;
  } summary_t;

  typedef enum int {
    L_FILE, L_OLD, L_NEW, L_HUNK, L_ADD, L_DEL, L_CTX, L_BINARY, L_NEAR, L_NOISE, L_EMPTY
  } line_pick_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_text_byte;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_WIDTH-1:0] out_file_total;
  logic [OUT_WIDTH-1:0] out_hunk_total;
  logic [OUT_WIDTH-1:0] out_added_total;
  logic [OUT_WIDTH-1:0] out_deleted_total;
  logic                 out_binary_flag;
  logic                 out_malformed;

  string prefix_text [NUM_PREFIX] = '{"diff --git ", "--- ", "+++ ", "@@", "+++", "---"};
  string binary_text = "Binary files ";
  string odd_chars = "+-@ Bdifgtny";
  string near_miss [12] = '{"diff --git", "diff -", "--", "---", "+++", "++", "@",
                            "Binary file", "BBinary files ", "+Binary files ", "-++ ", "+-- "};

  // line scanner and tally state
  int                         col;
  logic [NUM_PREFIX-1:0]      pfx_live;
  logic [7:0]                 lead_char;
  logic [3:0]                 bin_prog;
  logic                       bin_in_line;
  logic                       old_hdr;
  logic [COUNT_WIDTH_DEF-1:0] n_files;
  logic [COUNT_WIDTH_DEF-1:0] n_hunks;
  logic [COUNT_WIDTH_DEF-1:0] n_added;
  logic [COUNT_WIDTH_DEF-1:0] n_deleted;
  logic                       saw_binary;
  logic                       saw_malformed;

  summary_t pending_sums[$];
  int       errors = 0;
  int       bytes_sent = 0;
  int       hold_left = 0;
  bit       steady = 1'b0;

  unified_diff_line_summarizer_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_text_byte      (in_text_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_file_total    (out_file_total),
    .out_hunk_total    (out_hunk_total),
    .out_added_total   (out_added_total),
    .out_deleted_total (out_deleted_total),
    .out_binary_flag   (out_binary_flag),
    .out_malformed     (out_malformed)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [COUNT_WIDTH_DEF-1:0] bump(input logic [COUNT_WIDTH_DEF-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic bit prefix_hit(input logic [2:0] k);
    return pfx_live[k] && (col >= prefix_text[k].len());
  endfunction

  task automatic clear_line();
    col = 0;
    pfx_live = '1;
    lead_char = BYTE_NUL;
    bin_prog = '0;
    bin_in_line = 1'b0;
  endtask

  task automatic clear_tally();
    clear_line();
    old_hdr = 1'b0;
    n_files = '0;
    n_hunks = '0;
    n_added = '0;
    n_deleted = '0;
    saw_binary = 1'b0;
    saw_malformed = 1'b0;
  endtask

  task automatic classify_line();
    if (prefix_hit(PFX_DIFF_GIT)) begin
      n_files = bump(n_files);
      old_hdr = 1'b0;
    end else if (prefix_hit(PFX_OLD_HDR)) begin
      old_hdr = 1'b1;
    end else if (prefix_hit(PFX_NEW_HDR)) begin
      if (!old_hdr) saw_malformed = 1'b1;
    end else if (prefix_hit(PFX_HUNK)) begin
      n_hunks = bump(n_hunks);
    end else if (col > 0 && lead_char == CHAR_PLUS && !prefix_hit(PFX_PLUS3)) begin
      n_added = bump(n_added);
    end else if (col > 0 && lead_char == CHAR_MINUS && !prefix_hit(PFX_MINUS3)) begin
      n_deleted = bump(n_deleted);
    end else if (bin_in_line) begin
      saw_binary = 1'b1;
    end
    clear_line();
  endtask

  task automatic scan_char(input logic [7:0] ch);
    if (col >= LINE_BUFFER_DEF - 1) return;
    if (col == 0) lead_char = ch;
    for (int k = 0; k < NUM_PREFIX; k++) begin
      if (col < prefix_text[k].len() && ch != prefix_text[k][col]) pfx_live[k] = 1'b0;
    end
    if (!bin_in_line) begin
      if (ch == binary_text[bin_prog]) begin
        bin_prog++;
        if (bin_prog >= BIN_LEN) begin
          bin_in_line = 1'b1;
          bin_prog = '0;
        end
      end else begin
        bin_prog = (ch == CHAR_B) ? 4'd1 : 4'd0;
      end
    end
    col++;
  endtask

  task automatic predict_byte(input logic [7:0] ch);
    summary_t s;
    if (ch == BYTE_NUL) begin
      classify_line();
      s.files = n_files;
      s.hunks = n_hunks;
      s.added = n_added;
      s.deleted = n_deleted;
      s.binary = saw_binary;
      s.malformed = saw_malformed;
      pending_sums.push_back(s);
      clear_tally();
    end else if (ch == BYTE_LF) begin
      classify_line();
    end else begin
      scan_char(ch);
    end
  endtask

  task automatic send_byte(input logic [7:0] ch);
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 15) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_text_byte = ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(ch);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_text_line(input string s);
    send_text(s);
    send_byte(BYTE_LF);
  endtask

  task automatic send_fill(input string c, input int n);
    repeat (n) send_byte(c[0]);
  endtask

  task automatic send_body(input int n);
    logic [7:0] ch;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) ch = odd_chars[$urandom_range(0, odd_chars.len() - 1)];
      else ch = 8'($urandom_range(1, 255));
      if (ch == BYTE_LF) ch = CHAR_B;
      send_byte(ch);
    end
  endtask

  task automatic send_line(input line_pick_t kind, input bit close);
    case (kind)
      L_FILE: begin
        send_text("diff --git a/");
        send_body($urandom_range(0, 6));
      end
      L_OLD: begin
        send_text("--- ");
        send_body($urandom_range(0, 6));
      end
      L_NEW: begin
        send_text("+++ ");
        send_body($urandom_range(0, 6));
      end
      L_HUNK: begin
        send_text("@@ -1 +1 @@");
        send_body($urandom_range(0, 4));
      end
      L_ADD: begin
        send_text("+");
        send_body($urandom_range(0, 8));
      end
      L_DEL: begin
        send_text("-");
        send_body($urandom_range(0, 8));
      end
      L_CTX: begin
        send_text(" ");
        send_body($urandom_range(0, 8));
      end
      L_BINARY: begin
        send_body($urandom_range(0, 4));
        send_text(binary_text);
        send_body($urandom_range(0, 6));
      end
      L_NEAR: begin
        send_text(near_miss[$urandom_range(0, 11)]);
        send_body($urandom_range(0, 3));
      end
      L_NOISE: send_body($urandom_range(1, 12));
      default: ;
    endcase
    if (close) send_byte(BYTE_LF);
  endtask

  task automatic send_patch_random();
    int nf;
    int nh;
    int nl;
    if ($urandom_range(0, 99) < 75) begin
      nf = $urandom_range(0, 2);
      repeat (nf) begin
        send_line(L_FILE, 1'b1);
        if ($urandom_range(0, 99) < 15) begin
          send_line(L_BINARY, 1'b1);
        end else begin
          send_line(L_OLD, 1'b1);
          send_line(L_NEW, 1'b1);
          nh = $urandom_range(1, 2);
          repeat (nh) begin
            send_line(L_HUNK, 1'b1);
            nl = $urandom_range(1, 4);
            repeat (nl) send_line(line_pick_t'($urandom_range(L_ADD, L_CTX)), 1'b1);
          end
        end
      end
    end else begin
      nl = $urandom_range(0, 5);
      repeat (nl) send_line(line_pick_t'($urandom_range(L_FILE, L_EMPTY)), 1'b1);
    end
    if ($urandom_range(0, 99) < 30) send_line(line_pick_t'($urandom_range(L_FILE, L_EMPTY)), 1'b0);
    send_byte(BYTE_NUL);
  endtask

  task automatic test_empty_patches();
    send_byte(BYTE_NUL);
    send_byte(BYTE_LF);
    send_byte(BYTE_NUL);
    send_text_line("+a");
    send_byte(BYTE_NUL);
    send_text("-b");
    send_byte(BYTE_NUL);
  endtask

  task automatic test_line_rules();
    send_text_line("diff --git x");
    send_text_line("diff --git");
    send_text_line("@@ -1 +1 @@");
    send_text_line("@@");
    send_text_line("@");
    send_text_line("+");
    send_text_line("+a");
    send_text_line("++");
    send_text_line("+++");
    send_text_line("-");
    send_text_line("-z");
    send_text_line("--");
    send_text_line("---");
    send_text_line(" ctx");
    send_byte(BYTE_LF);
    send_byte(BYTE_NUL);
  endtask

  task automatic test_header_order();
    send_text_line("+++ b");
    send_byte(BYTE_NUL);
    send_text_line("--- a");
    send_text_line("+++ b");
    send_byte(BYTE_NUL);
    send_text_line("--- a");
    send_text_line("diff --git x");
    send_text_line("+++ b");
    send_byte(BYTE_NUL);
    send_text_line("--- a");
    send_text_line("@@");
    send_text("+++ b");
    send_byte(BYTE_NUL);
    send_text_line("--- a");
    send_byte(BYTE_NUL);
    send_text("+++ ");
    send_byte(BYTE_NUL);
  endtask

  task automatic test_binary_detect();
    send_text_line("Binary files a and b differ");
    send_byte(BYTE_NUL);
    send_text("xBBinary files y");
    send_byte(BYTE_NUL);
    send_text_line("Binary files");
    send_byte(BYTE_NUL);
    send_text_line("+Binary files ");
    send_byte(BYTE_NUL);
    send_text_line("Binary fBinary files ");
    send_byte(BYTE_NUL);
    send_text_line("--- Binary files ");
    send_byte(BYTE_NUL);
  endtask

  task automatic test_long_lines();
    send_text("+");
    send_fill("x", 1100);
    send_byte(BYTE_LF);
    send_text_line("-d");
    send_byte(BYTE_NUL);
    // match ends on the last examined byte
    send_fill("y", 1010);
    send_text_line(binary_text);
    send_byte(BYTE_NUL);
    // match ends one byte past it
    send_fill("y", 1011);
    send_text_line(binary_text);
    send_byte(BYTE_NUL);
    send_text("diff --git ");
    send_fill("z", 1030);
    send_byte(BYTE_NUL);
  endtask

  task automatic test_output_backpressure();
    hold_left = 200;
    send_text_line("+x");
    send_byte(BYTE_NUL);
    send_byte(BYTE_NUL);
    send_text("-y");
    send_byte(BYTE_NUL);
    send_text("@@");
    send_byte(BYTE_NUL);
    send_byte(BYTE_NUL);
    send_text("diff --git ");
    send_byte(BYTE_NUL);
  endtask

  task automatic test_random_patches();
    int first;
    int n;
    first = bytes_sent;
    n = 0;
    while (bytes_sent - first < 1250 || n < 40) begin
      steady = (n >= 12 && n < 22);
      send_patch_random();
      n++;
    end
    steady = 1'b0;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : chk_summary
    summary_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        $error("summary request with nothing pending");
        errors++;
      end else begin
        want = pending_sums.pop_front();
        check_field("file_total", want.files, out_file_total);
        check_field("hunk_total", want.hunks, out_hunk_total);
        check_field("added_total", want.added, out_added_total);
        check_field("deleted_total", want.deleted, out_deleted_total);
        check_field("binary_flag", want.binary, out_binary_flag);
        check_field("malformed", want.malformed, out_malformed);
      end
    end
  end

  // output side readiness, with a counted hold-off on request
  always begin
    @(negedge clk);
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = steady || ($urandom_range(0, 99) >= 15);
    end
  end

  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_text_byte = BYTE_NUL;
    clear_tally();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_empty_patches();
    test_line_rules();
    test_header_order();
    test_binary_detect();
    test_long_lines();
    test_output_backpressure();
    test_random_patches();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
